### rtl/cpfm_pkg.sv
// Package for the capture period frequency meter: item types, widths, register
// indexes and filter thresholds.
// No dependencies; used by every file in rtl.
package cpfm_pkg;

    localparam int unsigned CNT_W      = 32;  // high count, intervals, periods
    localparam int unsigned LOW_W      = 16;  // captured low timer count
    localparam int unsigned TP_W       = 17;  // timer_period register
    localparam int unsigned MAXI_W     = 31;  // max_interval register
    localparam int unsigned NUM_W      = 32;  // freq_numerator register
    localparam int unsigned SUM_W      = 36;  // filter sum, no wrap
    localparam int unsigned SHIFT_W    = 3;   // filter shift amount, 1..4
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_NUMERATOR = 2'd2;

    // register reset values
    localparam logic [TP_W-1:0]   TIMER_PERIOD_RST   = 17'd65536;
    localparam logic [MAXI_W-1:0] MAX_INTERVAL_RST   = 31'd100000;
    localparam logic [NUM_W-1:0]  FREQ_NUMERATOR_RST = 32'd1000000;

    // filter weight bands: below each bound the given shift applies
    localparam logic [CNT_W-1:0] BAND_16_LIMIT = 32'd300;
    localparam logic [CNT_W-1:0] BAND_8_LIMIT  = 32'd1000;
    localparam logic [CNT_W-1:0] BAND_4_LIMIT  = 32'd2000;

    localparam logic [SHIFT_W-1:0] SHIFT_16 = 3'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_8  = 3'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_4  = 3'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_2  = 3'd1;

    localparam logic OP_CAPTURE  = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    typedef struct packed {
        logic             op;
        logic [LOW_W-1:0] capture_value;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] interval;
        logic [CNT_W-1:0] filtered_period;
        logic [CNT_W-1:0] freq_x10;
        logic             lost_pulse;
    } rsp_t;

endpackage

### rtl/cpfm_mul.sv
// Bit-serial shift-add multiplier, 32 x 17 bits, product modulo 2^32.
// Depends on cpfm_pkg.
module cpfm_mul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpfm_pkg::CNT_W-1:0] mcand,
    input  logic [cpfm_pkg::TP_W-1:0]  mplier,
    output logic                       done,
    output logic [cpfm_pkg::CNT_W-1:0] product
);

    localparam int unsigned STEP_W = $clog2(cpfm_pkg::TP_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(cpfm_pkg::TP_W - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [cpfm_pkg::CNT_W-1:0] acc_reg;
    logic [cpfm_pkg::CNT_W-1:0] mcand_reg;
    logic [cpfm_pkg::TP_W-1:0]  mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[cpfm_pkg::CNT_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[cpfm_pkg::TP_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/cpfm_div.sv
// Bit-serial restoring divider, 32 / 32 bits, one quotient bit a cycle.
// Depends on cpfm_pkg. Divisor must be non-zero.
module cpfm_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cpfm_pkg::NUM_W-1:0] dividend,
    input  logic [cpfm_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [cpfm_pkg::NUM_W-1:0] quotient
);

    localparam int unsigned STEP_W = $clog2(cpfm_pkg::NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(cpfm_pkg::NUM_W - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [cpfm_pkg::CNT_W:0]   rem_reg;
    logic [cpfm_pkg::NUM_W-1:0] quot_reg;
    logic [cpfm_pkg::CNT_W-1:0] dsor_reg;

    logic [cpfm_pkg::CNT_W:0]   rem_shift;
    logic [cpfm_pkg::CNT_W:0]   trial;

    assign rem_shift = {rem_reg[cpfm_pkg::CNT_W-1:0], quot_reg[cpfm_pkg::NUM_W-1]};
    assign trial     = rem_shift - {1'b0, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // trial subtract; keep it when it does not go negative
            if (!trial[cpfm_pkg::CNT_W])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[cpfm_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                quot_reg <= {quot_reg[cpfm_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/capture_period_frequency_meter_unit.sv
// Capture period frequency meter top level; depends on cpfm_pkg, cpfm_mul and cpfm_div.
// Steps per item: serial multiply, decision, filter (S_FILT1, S_FILT2; skipped for a quiet
// overflow), range check, serial division when the period is in range, output hand-over.
// Items are taken one at a time, only in the idle state. The next item is taken while the
// previous result waits in the output register; a stalled result holds the sequencer.
// Reset (rst_n, async, active low) clears counts and filter state, loads register defaults.
module capture_period_frequency_meter_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // item input channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  cpfm_pkg::req_t                  req,
    // result channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output cpfm_pkg::rsp_t                  rsp,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpfm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] S_MUL   = 3'd1;  // serial high-count x timer_period
    localparam logic [2:0] S_DEC   = 3'd2;  // capture / timeout decision, state update
    localparam logic [2:0] S_FILT1 = 3'd3;  // s * (2^k - 1)
    localparam logic [2:0] S_FILT2 = 3'd4;  // add sample, shift down
    localparam logic [2:0] S_FREQ  = 3'd5;  // range check, launch division
    localparam logic [2:0] S_DIVW  = 3'd6;  // serial division running
    localparam logic [2:0] S_OUT   = 3'd7;  // hand result to output register

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [cpfm_pkg::TP_W-1:0]   tp_reg;
    logic [cpfm_pkg::MAXI_W-1:0] max_reg;
    logic [cpfm_pkg::NUM_W-1:0]  num_reg;

    // measurement state
    logic [cpfm_pkg::CNT_W-1:0] hc_reg;
    logic [cpfm_pkg::CNT_W-1:0] prev_high_reg;
    logic [cpfm_pkg::LOW_W-1:0] prev_low_reg;
    logic [cpfm_pkg::CNT_W-1:0] last_reg;
    logic [cpfm_pkg::CNT_W-1:0] s_reg;

    // per-item working registers
    logic                         op_reg;
    logic [cpfm_pkg::LOW_W-1:0]   low_reg;
    logic [cpfm_pkg::CNT_W-1:0]   d_reg;
    logic [cpfm_pkg::CNT_W-1:0]   sample_reg;
    logic [cpfm_pkg::SHIFT_W-1:0] k_reg;
    logic [cpfm_pkg::SUM_W-1:0]   acc_reg;
    logic [cpfm_pkg::CNT_W-1:0]   freq_reg;
    logic                         lost_reg;

    // output register
    logic           rsp_valid_reg;
    cpfm_pkg::rsp_t rsp_reg;

    logic accept;
    logic rsp_free;

    logic [cpfm_pkg::CNT_W-1:0] h_cur;
    logic [cpfm_pkg::CNT_W-1:0] high_diff;
    logic [cpfm_pkg::CNT_W-1:0] d_calc;
    logic [cpfm_pkg::CNT_W-1:0] max_ext;
    logic [cpfm_pkg::SUM_W-1:0] s_ext;
    logic [cpfm_pkg::SUM_W-1:0] sum_shift;
    logic                       freq_ok;

    logic                       mul_done;
    logic [cpfm_pkg::CNT_W-1:0] mul_product;
    logic                       div_start;
    logic                       div_done;
    logic [cpfm_pkg::NUM_W-1:0] div_quot;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;

    // time of this item: an overflow counts first, then compares against prev capture
    assign h_cur     = (req.op == cpfm_pkg::OP_OVERFLOW) ? hc_reg + 1'b1 : hc_reg;
    assign high_diff = (h_cur > prev_high_reg) ? h_cur - prev_high_reg : '0;

    // low part: added when it does not go below prev_low, or when the high part is
    // non-zero (then it borrows, modulo 2^32); otherwise the difference stays zero
    always_comb
    begin
        d_calc = mul_product;
        if ((low_reg >= prev_low_reg) || (mul_product != '0))
            d_calc = mul_product + {{(cpfm_pkg::CNT_W - cpfm_pkg::LOW_W){1'b0}}, low_reg}
                   - {{(cpfm_pkg::CNT_W - cpfm_pkg::LOW_W){1'b0}}, prev_low_reg};
    end

    assign max_ext   = {1'b0, max_reg};
    assign s_ext     = {{(cpfm_pkg::SUM_W - cpfm_pkg::CNT_W){1'b0}}, s_reg};
    assign sum_shift = (acc_reg + {{(cpfm_pkg::SUM_W - cpfm_pkg::CNT_W){1'b0}}, sample_reg})
                       >> k_reg;
    assign freq_ok   = (s_reg != '0) && (s_reg <= max_ext);
    assign div_start = (state_reg == S_FREQ) && freq_ok;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MUL;
            S_MUL:   if (mul_done) state_next = S_DEC;
            S_DEC:
            begin
                if (op_reg == cpfm_pkg::OP_CAPTURE || d_reg > max_ext)
                    state_next = S_FILT1;
                else
                    state_next = S_FREQ;
            end
            S_FILT1: state_next = S_FILT2;
            S_FILT2: state_next = S_FREQ;
            S_FREQ:  state_next = freq_ok ? S_DIVW : S_OUT;
            S_DIVW:  if (div_done) state_next = S_OUT;
            S_OUT:   if (rsp_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg  <= cpfm_pkg::TIMER_PERIOD_RST;
            max_reg <= cpfm_pkg::MAX_INTERVAL_RST;
            num_reg <= cpfm_pkg::FREQ_NUMERATOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cpfm_pkg::REG_TIMER_PERIOD:   tp_reg  <= cfg_data[cpfm_pkg::TP_W-1:0];
                cpfm_pkg::REG_MAX_INTERVAL:   max_reg <= cfg_data[cpfm_pkg::MAXI_W-1:0];
                cpfm_pkg::REG_FREQ_NUMERATOR: num_reg <= cfg_data[cpfm_pkg::NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // measurement state and filter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= '0;
            prev_high_reg <= '0;
            prev_low_reg  <= '0;
            last_reg      <= '0;
            s_reg         <= '0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lost_reg <= 1'b0;
                if (req.op == cpfm_pkg::OP_OVERFLOW)
                    hc_reg <= h_cur;
            end
            if (state_reg == S_DEC)
            begin
                if (op_reg == cpfm_pkg::OP_CAPTURE)
                begin
                    prev_high_reg <= hc_reg;
                    prev_low_reg  <= low_reg;
                    last_reg      <= d_reg;
                end
                else if (d_reg > max_ext)
                begin
                    // pulse lost: feed twice the limit into a quarter-weight filter
                    prev_high_reg <= hc_reg;
                    prev_low_reg  <= '0;
                    last_reg      <= {max_reg, 1'b0};
                    lost_reg      <= 1'b1;
                end
            end
            if (state_reg == S_FILT2)
                s_reg <= sum_shift[cpfm_pkg::CNT_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            low_reg <= (req.op == cpfm_pkg::OP_OVERFLOW) ? '0 : req.capture_value;
        end
        if (state_reg == S_MUL && mul_done)
            d_reg <= d_calc;
        if (state_reg == S_DEC)
        begin
            if (op_reg == cpfm_pkg::OP_CAPTURE)
            begin
                sample_reg <= d_reg;
                if (d_reg < cpfm_pkg::BAND_16_LIMIT)
                    k_reg <= cpfm_pkg::SHIFT_16;
                else if (d_reg < cpfm_pkg::BAND_8_LIMIT)
                    k_reg <= cpfm_pkg::SHIFT_8;
                else if (d_reg < cpfm_pkg::BAND_4_LIMIT)
                    k_reg <= cpfm_pkg::SHIFT_4;
                else
                    k_reg <= cpfm_pkg::SHIFT_2;
            end
            else
            begin
                sample_reg <= {max_reg, 1'b0};
                k_reg      <= cpfm_pkg::SHIFT_4;
            end
        end
        if (state_reg == S_FILT1)
            acc_reg <= (s_ext << k_reg) - s_ext;
        if (state_reg == S_FREQ)
            freq_reg <= '0;
        else if (state_reg == S_DIVW && div_done)
            freq_reg <= div_quot;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && rsp_free)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && rsp_free)
        begin
            rsp_reg.interval        <= last_reg;
            rsp_reg.filtered_period <= s_reg;
            rsp_reg.freq_x10        <= freq_reg;
            rsp_reg.lost_pulse      <= lost_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    cpfm_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .mcand   (high_diff),
        .mplier  (tp_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    cpfm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (s_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTHESIS
    // a new result only ever comes from the hand-over state
    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside hand-over state");

    // the divider is never launched on a zero period
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (s_reg != '0))
        else $error("division by zero period launched");

    // a held result with a period beyond the limit reports no frequency
    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.filtered_period > max_ext)) |-> (rsp_reg.freq_x10 == '0))
        else $error("frequency reported for out-of-range period");

    // lost pulse is flagged by overflow items only
    a_lost_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && lost_reg) |-> (op_reg == cpfm_pkg::OP_OVERFLOW))
        else $error("lost pulse flagged on a capture item");
`endif

endmodule

### tb/cpfm_meter_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the capture period frequency meter: watches the item, result and
// register channels, predicts each result and compares it field by field.
// Depends on cpfm_pkg.
module cpfm_meter_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  cpfm_pkg::req_t                  req,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  cpfm_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpfm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              n_pending
);

    // IIR weights on the old period, one per band
    localparam logic [3:0] WEIGHT_16 = 4'd15;
    localparam logic [3:0] WEIGHT_8  = 4'd7;
    localparam logic [3:0] WEIGHT_4  = 4'd3;
    localparam logic [3:0] WEIGHT_2  = 4'd1;

    logic [cpfm_pkg::TP_W-1:0]   tp_q;
    logic [cpfm_pkg::MAXI_W-1:0] max_q;
    logic [cpfm_pkg::NUM_W-1:0]  num_q;

    logic [cpfm_pkg::CNT_W-1:0]  high_cnt;
    logic [cpfm_pkg::CNT_W-1:0]  cap_high;
    logic [cpfm_pkg::LOW_W-1:0]  cap_low;
    logic [cpfm_pkg::CNT_W-1:0]  sample_iv;
    logic [cpfm_pkg::CNT_W-1:0]  avg_period;

    cpfm_pkg::rsp_t expected_readings[$];
    int             mismatches  = 0;
    int             outstanding = 0;

    assign fail_count = mismatches;
    assign n_pending  = outstanding;

    task automatic report_mismatch(input string what,
                                   input logic [cpfm_pkg::CNT_W-1:0] got,
                                   input logic [cpfm_pkg::CNT_W-1:0] want);
        mismatches++;
        $display("%0t checker: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ticks from the last capture to (h, l), modulo 2^32
    function automatic logic [cpfm_pkg::CNT_W-1:0] ticks_since(
        input logic [cpfm_pkg::CNT_W-1:0] h,
        input logic [cpfm_pkg::LOW_W-1:0] l);
        logic [cpfm_pkg::CNT_W-1:0] d;
        logic [cpfm_pkg::CNT_W-1:0] tp_ext;
        logic [cpfm_pkg::CNT_W-1:0] l_ext;
        logic [cpfm_pkg::CNT_W-1:0] prev_l_ext;
        tp_ext     = {{(cpfm_pkg::CNT_W - cpfm_pkg::TP_W){1'b0}}, tp_q};
        l_ext      = {{(cpfm_pkg::CNT_W - cpfm_pkg::LOW_W){1'b0}}, l};
        prev_l_ext = {{(cpfm_pkg::CNT_W - cpfm_pkg::LOW_W){1'b0}}, cap_low};
        d = '0;
        if (h > cap_high)
            d = (h - cap_high) * tp_ext;
        if (l >= cap_low)
            d = d + l_ext - prev_l_ext;
        else if (d != '0)
            d = d - prev_l_ext + l_ext;
        return d;
    endfunction

    function automatic logic [cpfm_pkg::CNT_W-1:0] iir(
        input logic [cpfm_pkg::CNT_W-1:0]   sample,
        input logic [3:0]                   weight,
        input logic [cpfm_pkg::SHIFT_W-1:0] shift);
        logic [cpfm_pkg::SUM_W-1:0] acc;
        acc = {{(cpfm_pkg::SUM_W - cpfm_pkg::CNT_W){1'b0}}, sample}
            + {{(cpfm_pkg::SUM_W - cpfm_pkg::CNT_W){1'b0}}, avg_period}
            * {{(cpfm_pkg::SUM_W - 4){1'b0}}, weight};
        acc = acc >> shift;
        return acc[cpfm_pkg::CNT_W-1:0];
    endfunction

    // advances the meter state by one item and returns the result it gives
    function automatic cpfm_pkg::rsp_t next_reading(input cpfm_pkg::req_t item);
        cpfm_pkg::rsp_t             r;
        logic [cpfm_pkg::CNT_W-1:0] iv;
        logic [cpfm_pkg::CNT_W-1:0] max_ext;
        max_ext      = {1'b0, max_q};
        r.lost_pulse = 1'b0;
        if (item.op == cpfm_pkg::OP_CAPTURE)
        begin
            iv        = ticks_since(high_cnt, item.capture_value);
            cap_high  = high_cnt;
            cap_low   = item.capture_value;
            sample_iv = iv;
            if (iv < cpfm_pkg::BAND_16_LIMIT)
                avg_period = iir(iv, WEIGHT_16, cpfm_pkg::SHIFT_16);
            else if (iv < cpfm_pkg::BAND_8_LIMIT)
                avg_period = iir(iv, WEIGHT_8, cpfm_pkg::SHIFT_8);
            else if (iv < cpfm_pkg::BAND_4_LIMIT)
                avg_period = iir(iv, WEIGHT_4, cpfm_pkg::SHIFT_4);
            else
                avg_period = iir(iv, WEIGHT_2, cpfm_pkg::SHIFT_2);
        end
        else
        begin
            high_cnt = high_cnt + 1'b1;
            if (ticks_since(high_cnt, '0) > max_ext)
            begin
                iv           = {max_q, 1'b0};
                sample_iv    = iv;
                avg_period   = iir(iv, WEIGHT_4, cpfm_pkg::SHIFT_4);
                cap_high     = high_cnt;
                cap_low      = '0;
                r.lost_pulse = 1'b1;
            end
        end
        r.interval        = sample_iv;
        r.filtered_period = avg_period;
        if (avg_period != '0 && avg_period <= max_ext)
            r.freq_x10 = num_q / avg_period;
        else
            r.freq_x10 = '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        cpfm_pkg::rsp_t want;
        if (!rst_n)
        begin
            tp_q       = cpfm_pkg::TIMER_PERIOD_RST;
            max_q      = cpfm_pkg::MAX_INTERVAL_RST;
            num_q      = cpfm_pkg::FREQ_NUMERATOR_RST;
            high_cnt   = '0;
            cap_high   = '0;
            cap_low    = '0;
            sample_iv  = '0;
            avg_period = '0;
            expected_readings.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("result with no item outstanding, interval",
                                    rsp.interval, '0);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (rsp.interval !== want.interval)
                        report_mismatch("interval", rsp.interval, want.interval);
                    if (rsp.filtered_period !== want.filtered_period)
                        report_mismatch("filtered_period", rsp.filtered_period,
                                        want.filtered_period);
                    if (rsp.freq_x10 !== want.freq_x10)
                        report_mismatch("freq_x10", rsp.freq_x10, want.freq_x10);
                    if (rsp.lost_pulse !== want.lost_pulse)
                        report_mismatch("lost_pulse", 32'(rsp.lost_pulse),
                                        32'(want.lost_pulse));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cpfm_pkg::REG_TIMER_PERIOD:   tp_q  = cfg_data[cpfm_pkg::TP_W-1:0];
                    cpfm_pkg::REG_MAX_INTERVAL:   max_q = cfg_data[cpfm_pkg::MAXI_W-1:0];
                    cpfm_pkg::REG_FREQ_NUMERATOR: num_q = cfg_data[cpfm_pkg::NUM_W-1:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                expected_readings.push_back(next_reading(req));
            outstanding = expected_readings.size();
        end
    end

endmodule

### tb/tb_capture_period_frequency_meter_unit.sv
`timescale 1ns / 100ps
// Top of the frequency meter testbench: clock, reset, register set-up and item traffic.
// Depends on cpfm_pkg, the meter RTL and cpfm_meter_checker.
module tb_capture_period_frequency_meter_unit;

    // index with no register behind it; writes to it must be dropped
    localparam logic [cpfm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // worst case is an item with a division; leave margin
    localparam int DRAIN_CYCLES = 80;
    // long receiver hold-off, far beyond what the output stage can absorb
    localparam int HOLD_CYCLES  = 400;
    // ~930 items fit many times over
    localparam int LIMIT_NS     = 2_000_000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    cpfm_pkg::req_t                  req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    cpfm_pkg::rsp_t                  rsp;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cpfm_pkg::CFG_IDX_W-1:0]  cfg_index = cpfm_pkg::REG_TIMER_PERIOD;
    logic [cpfm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int n_pending;

    // idling percentages for the current phase
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_request  = 1'b0;
    logic long_hold     = 1'b0;

    // low timer count of the emulated pulse source, in ticks
    int unsigned tick_low = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    capture_period_frequency_meter_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cpfm_meter_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .n_pending  (n_pending)
    );

    // Result side: random stalls at the phase's rate, plus the long hold-off.
    always @(negedge clk)
    begin
        rsp_stall <= long_hold || (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // Long hold-off, counted here so the sender keeps offering items meanwhile
    // and the meter backs up into its input.
    initial
    begin : hold_off_proc
        wait (hold_request);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
    end

    // Offers one item; called and returns at a falling edge. Valid stays high on
    // return so back-to-back items need no low cycle.
    task automatic send_item(input logic op, input logic [cpfm_pkg::LOW_W-1:0] value);
        cpfm_pkg::req_t item;
        item.op            = op;
        item.capture_value = value;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_reg(input logic [cpfm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpfm_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [cpfm_pkg::CFG_DATA_W-1:0] tp,
                                 input logic [cpfm_pkg::CFG_DATA_W-1:0] max_iv,
                                 input logic [cpfm_pkg::CFG_DATA_W-1:0] num);
        write_reg(cpfm_pkg::REG_TIMER_PERIOD, tp);
        write_reg(cpfm_pkg::REG_MAX_INTERVAL, max_iv);
        write_reg(cpfm_pkg::REG_FREQ_NUMERATOR, num);
        cfg_valid <= 1'b0;
    endtask

    // Lets every outstanding item come back, then waits out the pipeline so the
    // meter is idle before registers change.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (n_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Traffic shaped like a real pulse train: the emulated timer runs on by a
    // random number of ticks, the overflows that passes are sent (at most 12), then the
    // capture. A quarter of the picks are instead one noise item with random content.
    task automatic pulse_traffic(input int n_items, input int unsigned period);
        int          sent;
        int          pick;
        int unsigned delta;
        int unsigned total;
        int unsigned n_ovf;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                send_item(1'($urandom), 16'($urandom));
                sent++;
            end
            else
            begin
                // pick an interval band so every filter weight gets used
                if (pick < 40)
                    delta = $urandom_range(299, 0);
                else if (pick < 55)
                    delta = $urandom_range(999, 300);
                else if (pick < 70)
                    delta = $urandom_range(1999, 1000);
                else if (pick < 90)
                    delta = $urandom_range(3 * period + 2000, 2000);
                else
                    delta = $urandom_range(8 * period, 3 * period);  // quiet spell
                total    = tick_low + delta;
                n_ovf    = total / period;
                tick_low = total % period;
                if (n_ovf > 12)
                    n_ovf = 12;
                repeat (n_ovf)
                begin
                    send_item(cpfm_pkg::OP_OVERFLOW, 16'($urandom));
                    sent++;
                end
                send_item(cpfm_pkg::OP_CAPTURE, tick_low[cpfm_pkg::LOW_W-1:0]);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus_proc
        logic [cpfm_pkg::CFG_DATA_W-1:0] rnd_tp;
        int unsigned                     rnd_period;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at reset settings (timer_period 65536, max 100000).
        send_item(cpfm_pkg::OP_CAPTURE, 16'h0000);   // zero interval, zero period, no frequency
        send_item(cpfm_pkg::OP_CAPTURE, 16'hFFFF);   // largest low count
        send_item(cpfm_pkg::OP_CAPTURE, 16'h0000);   // low count going back with no high part
        send_item(cpfm_pkg::OP_CAPTURE, 16'd299);    // band edges: 299, 300, 999, 1000, 1999, 2000
        send_item(cpfm_pkg::OP_CAPTURE, 16'd599);
        send_item(cpfm_pkg::OP_CAPTURE, 16'd1598);
        send_item(cpfm_pkg::OP_CAPTURE, 16'd2598);
        send_item(cpfm_pkg::OP_CAPTURE, 16'd4597);
        send_item(cpfm_pkg::OP_CAPTURE, 16'd6597);
        send_item(cpfm_pkg::OP_OVERFLOW, 16'h0000);  // quiet overflow repeats the last interval
        send_item(cpfm_pkg::OP_CAPTURE, 16'd50);     // borrow from the high part
        send_item(cpfm_pkg::OP_OVERFLOW, 16'hFFFF);  // capture field ignored on overflow
        send_item(cpfm_pkg::OP_OVERFLOW, 16'h5A5A);  // past max_interval: lost pulse
        send_item(cpfm_pkg::OP_OVERFLOW, 16'h0000);
        send_item(cpfm_pkg::OP_OVERFLOW, 16'hA5A5);  // lost again
        send_item(cpfm_pkg::OP_CAPTURE, 16'hFFFF);
        send_item(cpfm_pkg::OP_OVERFLOW, 16'h0001);
        drain_results();

        // Short timer, tight timeout; long receiver hold-off with the sender flat out.
        load_settings(32'd1000, 32'd5000, 32'd10_000_000);
        tick_low     = 0;
        hold_request = 1'b1;
        pulse_traffic(250, 1000);
        drain_results();

        // Top of the max_interval and freq_numerator ranges, timer_period 65536; sender idles.
        load_settings(32'd65536, 32'd2147483647, 32'hFFFF_FFFF);
        send_idle_pct = 62;
        tick_low      = 0;
        pulse_traffic(150, 65536);
        drain_results();

        // Bottom of every register range; receiver stalls.
        load_settings(32'd1, 32'd1, 32'd1);
        send_idle_pct = 0;
        stall_pct     = 62;
        tick_low      = 0;
        pulse_traffic(120, 1);
        drain_results();

        // Random register data, masked by the meter; the spare index is written too.
        rnd_tp = $urandom;
        write_reg(REG_UNUSED, $urandom);
        write_reg(cpfm_pkg::REG_TIMER_PERIOD, rnd_tp);
        write_reg(cpfm_pkg::REG_MAX_INTERVAL, $urandom);
        write_reg(cpfm_pkg::REG_FREQ_NUMERATOR, $urandom);
        cfg_valid <= 1'b0;
        rnd_period = 32'(rnd_tp[cpfm_pkg::TP_W-1:0]);
        if (rnd_period == 0 || rnd_period > 65536)
            rnd_period = 65536;
        send_idle_pct = 22;
        stall_pct     = 22;
        tick_low      = 0;
        pulse_traffic(120, rnd_period);
        drain_results();

        // Out of range: no timer period, no numerator.
        load_settings(32'd0, 32'd300, 32'd0);
        send_idle_pct = 62;
        stall_pct     = 0;
        tick_low      = 0;
        pulse_traffic(120, 4096);
        drain_results();

        // Mid-range settings to finish; receiver stalls again.
        load_settings(32'd200, 32'd3000, 32'd2_000_000);
        send_idle_pct = 0;
        stall_pct     = 62;
        tick_low      = 0;
        pulse_traffic(150, 200);
        drain_results();

        if (fail_count == 0)
            $display("tb_capture_period_frequency_meter_unit: PASS");
        else
            $display("tb_capture_period_frequency_meter_unit: FAIL");
        $finish;
    end

    initial
    begin : watchdog_proc
        #(LIMIT_NS);
        $display("tb_capture_period_frequency_meter_unit: FAIL");
        $finish;
    end

endmodule

### capture_period_frequency_meter_unit.f
rtl/cpfm_pkg.sv
rtl/cpfm_mul.sv
rtl/cpfm_div.sv
rtl/capture_period_frequency_meter_unit.sv
tb/cpfm_meter_checker.sv
tb/tb_capture_period_frequency_meter_unit.sv
